>>> rtl/core/lfu_byte_budget_pool_defines.svh
// Assertion macros for the byte budget pool
`ifndef LFU_BYTE_BUDGET_POOL_DEFINES_SVH
`define LFU_BYTE_BUDGET_POOL_DEFINES_SVH
`ifndef SYNTHESIS
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LBP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/lbp_pkg.sv
// Package: types, codes and defaults for the byte budget pool
package lbp_pkg;
    localparam int NUM_SLOTS_DEF = 16;
    localparam int FREQ_BITS_DEF = 16;
    localparam logic [31:0] CAP_RESET = 32'd65536;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_TOUCH = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        K_EVICT   = 3'd0,
        K_ALLOC   = 3'd1,
        K_FAIL    = 3'd2,
        K_TOUCH   = 3'd3,
        K_FREED   = 3'd4,
        K_UNKNOWN = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_HREAD,
        S_HDO,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] block_size;
        logic [3:0]  handle;
    } t_req_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] slot_bytes;
        logic [31:0] bytes_in_use;
        logic        last;
    } t_res_item;
endpackage

>>> rtl/core/lbp_if.sv
// Valid/ready channel interfaces for requests, results and configuration
interface lbp_req_if;
    logic                 valid;
    logic                 ready;
    lbp_pkg::t_req_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbp_res_if;
    logic                 valid;
    logic                 ready;
    lbp_pkg::t_res_item   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lbp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lfu_byte_budget_pool.sv
// Top level: byte budget LFU slot pool
// One request at a time. A touch, a free or an unknown handle passes through S_HREAD and
// S_HDO before the next request can transfer. An allocate without eviction needs S_DECIDE only.
// Each eviction adds a full scan of the slot table through the single read port of the slot
// memory, the emit, and a wait for the eviction result to leave the output register before
// the decision. Each result sits in an output register until transferred.
// A new request may transfer while the previous result waits. Emitting, deciding and the
// handle step (S_HDO) hold while a result waits.
// Scanning does not hold.
`include "lfu_byte_budget_pool_defines.svh"
module lfu_byte_budget_pool #(
    parameter int NUM_SLOTS = lbp_pkg::NUM_SLOTS_DEF,
    parameter int FREQ_BITS = lbp_pkg::FREQ_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    lbp_req_if.sink   i_req,
    lbp_res_if.source o_res,
    lbp_cfg_if.sink   i_cfg
);
    localparam int AW = $clog2(NUM_SLOTS);
    localparam int DW = 32 + FREQ_BITS + 32;
    localparam logic [FREQ_BITS-1:0] FMAX = '1;

    lbp_pkg::t_state r_state, n_state;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [31:0] r_cap, r_used, n_used, r_ctr, n_ctr;
    lbp_pkg::t_req_item r_req, n_req;
    lbp_pkg::t_res_item r_out, n_out;
    logic r_ov, n_ov;
    logic [AW:0] r_idx, n_idx;
    logic [AW-1:0] r_cidx, n_cidx;
    logic r_rvld, n_rvld;
    logic r_bfound, n_bfound;
    logic [AW-1:0] r_bidx, n_bidx;
    logic [FREQ_BITS-1:0] r_bf, n_bf;
    logic [31:0] r_ba, n_ba, r_bsz, n_bsz;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;
    logic [31:0] rd_sz, rd_st, rd_age;
    logic [FREQ_BITS-1:0] rd_f;
    logic fits, has_free, hbad;
    logic [AW-1:0] ffree;

    lbp_slot_mem #(.NUM_SLOTS(NUM_SLOTS), .FREQ_BITS(FREQ_BITS)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rd_sz  = rdata[DW-1 -: 32];
    assign rd_f   = rdata[31+FREQ_BITS -: FREQ_BITS];
    assign rd_st  = rdata[31:0];
    assign rd_age = r_ctr - rd_st;
    assign fits   = ({1'b0, r_used} + {1'b0, r_req.block_size}) <= {1'b0, r_cap};
    assign has_free = ~&r_valid;
    assign hbad = ({28'd0, r_req.handle} >= 32'(NUM_SLOTS))
        || !r_valid[r_req.handle[AW-1:0]];

    always_comb begin
        ffree = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) ffree = AW'(i);
        end
    end

    assign i_req.ready = (r_state == lbp_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbp_pkg::S_IDLE;
            r_valid <= '0;
            r_used <= '0;
            r_ctr <= '0;
            r_ov <= 1'b0;
            r_cap <= lbp_pkg::CAP_RESET;
            r_rvld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used <= n_used;
            r_ctr <= n_ctr;
            r_ov <= n_ov;
            r_rvld <= n_rvld;
            if (i_cfg.valid) r_cap <= i_cfg.data;
        end
        r_req <= n_req;
        r_out <= n_out;
        r_idx <= n_idx;
        r_cidx <= n_cidx;
        r_bfound <= n_bfound;
        r_bidx <= n_bidx;
        r_bf <= n_bf;
        r_ba <= n_ba;
        r_bsz <= n_bsz;
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_used = r_used;
        n_ctr = r_ctr;
        n_req = r_req;
        n_out = r_out;
        n_ov = r_ov && !o_res.ready;
        n_idx = r_idx;
        n_cidx = r_cidx;
        n_rvld = 1'b0;
        n_bfound = r_bfound;
        n_bidx = r_bidx;
        n_bf = r_bf;
        n_ba = r_ba;
        n_bsz = r_bsz;
        we = 1'b0;
        waddr = r_req.handle[AW-1:0];
        wdata = '0;
        raddr = r_idx[AW-1:0];
        unique case (r_state)
            lbp_pkg::S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_req = i_req.data;
                    unique case (i_req.data.req_type) inside
                        lbp_pkg::REQ_ALLOC: n_state = lbp_pkg::S_DECIDE;
                        lbp_pkg::REQ_TOUCH, lbp_pkg::REQ_FREE: n_state = lbp_pkg::S_HREAD;
                        default: n_state = lbp_pkg::S_IDLE;
                    endcase
                end
            end
            lbp_pkg::S_DECIDE: begin
                if (!r_ov) begin
                    if (fits && has_free) begin
                        we = 1'b1;
                        waddr = ffree;
                        wdata = {r_req.block_size, FREQ_BITS'(1), r_ctr};
                        n_valid[ffree] = 1'b1;
                        n_ctr = r_ctr + 32'd1;
                        n_used = r_used + r_req.block_size;
                        n_out = '{lbp_pkg::K_ALLOC, 4'(ffree), r_req.block_size,
                            r_used + r_req.block_size, 1'b1};
                        n_ov = 1'b1;
                        n_state = lbp_pkg::S_IDLE;
                    end else if (r_valid == '0) begin
                        n_out = '{lbp_pkg::K_FAIL, 4'd0, r_req.block_size, r_used, 1'b1};
                        n_ov = 1'b1;
                        n_state = lbp_pkg::S_IDLE;
                    end else begin
                        n_idx = '0;
                        n_bfound = 1'b0;
                        n_state = lbp_pkg::S_SCAN;
                    end
                end
            end
            lbp_pkg::S_SCAN: begin
                if (r_rvld && r_valid[r_cidx]) begin
                    if (!r_bfound || rd_f < r_bf || (rd_f == r_bf && rd_age > r_ba)) begin
                        n_bfound = 1'b1;
                        n_bidx = r_cidx;
                        n_bf = rd_f;
                        n_ba = rd_age;
                        n_bsz = rd_sz;
                    end
                end
                if (r_idx < (AW+1)'(NUM_SLOTS)) begin
                    n_rvld = 1'b1;
                    n_cidx = r_idx[AW-1:0];
                    n_idx = r_idx + 1'b1;
                end else if (!r_rvld) begin
                    n_state = lbp_pkg::S_EMIT;
                end
            end
            lbp_pkg::S_EMIT: begin
                if (!r_ov) begin
                    n_valid[r_bidx] = 1'b0;
                    n_used = r_used - r_bsz;
                    n_out = '{lbp_pkg::K_EVICT, 4'(r_bidx), r_bsz, r_used - r_bsz, 1'b0};
                    n_ov = 1'b1;
                    n_state = lbp_pkg::S_DECIDE;
                end
            end
            lbp_pkg::S_HREAD: begin
                raddr = r_req.handle[AW-1:0];
                n_state = lbp_pkg::S_HDO;
            end
            lbp_pkg::S_HDO: begin
                // hold the read address so the slot data stays put while a result waits
                raddr = r_req.handle[AW-1:0];
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_state = lbp_pkg::S_IDLE;
                    if (hbad) begin
                        n_out = '{lbp_pkg::K_UNKNOWN, r_req.handle, 32'd0, r_used, 1'b1};
                    end else if (r_req.req_type == lbp_pkg::REQ_TOUCH) begin
                        we = 1'b1;
                        wdata = {rd_sz, (rd_f < FMAX) ? rd_f + 1'b1 : rd_f, r_ctr};
                        n_ctr = r_ctr + 32'd1;
                        n_out = '{lbp_pkg::K_TOUCH, r_req.handle, rd_sz, r_used, 1'b1};
                    end else begin
                        n_valid[r_req.handle[AW-1:0]] = 1'b0;
                        n_used = r_used - rd_sz;
                        n_out = '{lbp_pkg::K_FREED, r_req.handle, rd_sz, r_used - rd_sz, 1'b1};
                    end
                end
            end
            default: n_state = lbp_pkg::S_IDLE;
        endcase
    end

    `LBP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.data))
    `LBP_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, r_state != lbp_pkg::S_IDLE, !i_req.ready)
    `LBP_ASSERT_IMPL(a_evict_not_last, i_clk, i_rst_n, o_res.valid && o_res.data.kind == lbp_pkg::K_EVICT, !o_res.data.last)
    `LBP_ASSERT_NEXT(a_emit_found, i_clk, i_rst_n, r_state == lbp_pkg::S_SCAN && n_state == lbp_pkg::S_EMIT, r_bfound)
endmodule

>>> rtl/core/lbp_slot_mem.sv
// Slot table memory: size, frequency and order stamp per slot
module lbp_slot_mem #(
    parameter int NUM_SLOTS = lbp_pkg::NUM_SLOTS_DEF,
    parameter int FREQ_BITS = lbp_pkg::FREQ_BITS_DEF,
    localparam int AW = $clog2(NUM_SLOTS),
    localparam int DW = 32 + FREQ_BITS + 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

>>> tb/sv/tb_top.sv
// Testbench for the byte budget LFU slot pool: random and directed requests
`timescale 1ns / 1ps
module tb_top;
    localparam int NSLOT = 16;
    localparam logic [15:0] FREQ_TOP = 16'hFFFF;
    localparam int WDOG_LIMIT = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lbp_req_if req_ch();
    lbp_res_if res_ch();
    lbp_cfg_if cfg_ch();

    lfu_byte_budget_pool u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(req_ch.sink), .o_res(res_ch.source), .i_cfg(cfg_ch.sink)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] m_cap;
    logic        m_valid [NSLOT];
    logic [31:0] m_bytes [NSLOT];
    logic [15:0] m_freq  [NSLOT];
    logic [31:0] m_stamp [NSLOT];
    logic [31:0] m_order;
    logic [31:0] m_used;

    lbp_pkg::t_req_item pending_reqs[$];
    lbp_pkg::t_res_item expected_res[$];
    int errors = 0;
    int send_idle_pct = 26;
    int recv_idle_pct = 71;
    int idle_cycles = 0;
    logic req_xfer = 1'b0;

    function automatic void add_req(lbp_pkg::t_req_item it);
        pending_reqs.insert(pending_reqs.size(), it);
    endfunction

    function automatic void add_exp(lbp_pkg::t_res_item r);
        expected_res.insert(expected_res.size(), r);
    endfunction

    function automatic int first_free_slot();
        for (int i = 0; i < NSLOT; i++)
            if (!m_valid[i]) return i;
        return -1;
    endfunction

    function automatic int lfu_victim();
        int best;
        logic [15:0] bf;
        logic [31:0] ba, a;
        best = -1; bf = '0; ba = '0;
        for (int i = 0; i < NSLOT; i++) begin
            if (m_valid[i]) begin
                a = m_order - m_stamp[i];
                if (best < 0 || m_freq[i] < bf || (m_freq[i] == bf && a > ba)) begin
                    best = i; bf = m_freq[i]; ba = a;
                end
            end
        end
        return best;
    endfunction

    function automatic lbp_pkg::t_res_item mk_res(lbp_pkg::t_kind k, logic [3:0] s,
                                                  logic [31:0] b, logic l);
        lbp_pkg::t_res_item r;
        r.kind = k; r.slot = s; r.slot_bytes = b; r.bytes_in_use = m_used; r.last = l;
        return r;
    endfunction

    function automatic bit fits(logic [31:0] sz);
        return ({1'b0, m_used} + {1'b0, sz}) <= {1'b0, m_cap};
    endfunction

    task automatic predict_pool(lbp_pkg::t_req_item it);
        int v, s;
        case (it.req_type) inside
            lbp_pkg::REQ_ALLOC: begin
                forever begin
                    if (fits(it.block_size) && first_free_slot() >= 0) break;
                    v = lfu_victim();
                    if (v < 0) break;
                    m_valid[v] = 1'b0;
                    m_used = m_used - m_bytes[v];
                    add_exp(mk_res(lbp_pkg::K_EVICT, v[3:0], m_bytes[v], 1'b0));
                end
                s = first_free_slot();
                if (fits(it.block_size) && s >= 0) begin
                    m_valid[s] = 1'b1; m_bytes[s] = it.block_size; m_freq[s] = 16'd1;
                    m_stamp[s] = m_order; m_order = m_order + 32'd1;
                    m_used = m_used + it.block_size;
                    add_exp(mk_res(lbp_pkg::K_ALLOC, s[3:0], it.block_size, 1'b1));
                end else
                    add_exp(mk_res(lbp_pkg::K_FAIL, 4'd0, it.block_size, 1'b1));
            end
            lbp_pkg::REQ_TOUCH, lbp_pkg::REQ_FREE: begin
                if (!m_valid[it.handle])
                    add_exp(mk_res(lbp_pkg::K_UNKNOWN, it.handle, 32'd0, 1'b1));
                else if (it.req_type == lbp_pkg::REQ_TOUCH) begin
                    if (m_freq[it.handle] < FREQ_TOP) m_freq[it.handle]++;
                    m_stamp[it.handle] = m_order; m_order = m_order + 32'd1;
                    add_exp(mk_res(lbp_pkg::K_TOUCH, it.handle, m_bytes[it.handle], 1'b1));
                end else begin
                    m_valid[it.handle] = 1'b0;
                    m_used = m_used - m_bytes[it.handle];
                    add_exp(mk_res(lbp_pkg::K_FREED, it.handle, m_bytes[it.handle], 1'b1));
                end
            end
            default: ;
        endcase
    endtask

    // driver
    initial begin
        req_ch.valid = 1'b0; req_ch.data = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_ch.valid || req_xfer) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data <= pending_reqs[0];
                    pending_reqs.delete(0);
                end else
                    req_ch.valid <= 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            req_xfer <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) predict_pool(req_ch.data);
            if (res_ch.valid && res_ch.ready) begin
                lbp_pkg::t_res_item exp_r, got;
                got = res_ch.data;
                if (expected_res.size() == 0) begin
                    $error("result with nothing expected: kind %0d slot %0d", got.kind, got.slot);
                    errors++;
                end else begin
                    exp_r = expected_res[0];
                    expected_res.delete(0);
                    if (got.kind !== exp_r.kind) begin
                        $error("kind exp %0d got %0d", exp_r.kind, got.kind); errors++;
                    end
                    if (got.slot !== exp_r.slot) begin
                        $error("slot exp %0d got %0d", exp_r.slot, got.slot); errors++;
                    end
                    if (got.slot_bytes !== exp_r.slot_bytes) begin
                        $error("slot_bytes exp %0h got %0h", exp_r.slot_bytes, got.slot_bytes);
                        errors++;
                    end
                    if (got.bytes_in_use !== exp_r.bytes_in_use) begin
                        $error("bytes_in_use exp %0h got %0h", exp_r.bytes_in_use,
                               got.bytes_in_use);
                        errors++;
                    end
                    if (got.last !== exp_r.last) begin
                        $error("last exp %0d got %0d", exp_r.last, got.last); errors++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic lbp_pkg::t_req_item mk_req(lbp_pkg::t_req r, logic [31:0] sz,
                                                  logic [3:0] h);
        lbp_pkg::t_req_item it;
        it.req_type = r; it.block_size = sz; it.handle = h;
        return it;
    endfunction

    task automatic drain();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [31:0] cap);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1; cfg_ch.data <= cap;
        do @(posedge i_clk); while (!cfg_ch.ready);
        m_cap = cap;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(20000));
        endcase
    endfunction

    task automatic random_burst(int n);
        lbp_pkg::t_req r;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9)) inside
                [0:3]: r = lbp_pkg::REQ_ALLOC;
                [4:6]: r = lbp_pkg::REQ_TOUCH;
                [7:8]: r = lbp_pkg::REQ_FREE;
                default: r = lbp_pkg::REQ_NONE;
            endcase
            add_req(mk_req(r, rand_size(), 4'($urandom_range(15))));
        end
    endtask

    initial begin
        m_cap = lbp_pkg::CAP_RESET; m_order = '0; m_used = '0;
        for (int i = 0; i < NSLOT; i++) begin
            m_valid[i] = 1'b0; m_bytes[i] = '0; m_freq[i] = '0; m_stamp[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        add_req(mk_req(lbp_pkg::REQ_TOUCH, 32'd0, 4'd15));
        add_req(mk_req(lbp_pkg::REQ_FREE, 32'd0, 4'd0));
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd0, 4'd0));
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd65536, 4'd0));
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 4'd0));
        for (int i = 0; i < 8; i++)
            add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'(1000 + i), 4'hF));
        add_req(mk_req(lbp_pkg::REQ_TOUCH, 32'hFFFF_FFFF, 4'd3));
        add_req(mk_req(lbp_pkg::REQ_TOUCH, 32'd0, 4'd5));
        add_req(mk_req(lbp_pkg::REQ_FREE, 32'd0, 4'd2));
        add_req(mk_req(lbp_pkg::REQ_NONE, 32'hFFFF_FFFF, 4'hF));
        for (int i = 0; i < 9; i++)
            add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd500, 4'd0));
        drain();

        write_capacity(32'd100);
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd50, 4'd0));
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd101, 4'd0));
        random_burst(60);
        drain();

        write_capacity(32'hFFFF_FFFF);
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 4'd0));
        random_burst(60);
        drain();

        send_idle_pct = 71; recv_idle_pct = 26;
        write_capacity(32'd0);
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd0, 4'd0));
        add_req(mk_req(lbp_pkg::REQ_ALLOC, 32'd1, 4'd0));
        random_burst(20);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_capacity(32'd30000);
        random_burst(70);
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
